// ===== src/qdve_pkg.sv =====
// shared widths, codes and types for the quadrature decoder velocity estimator
package qdve_pkg;

  localparam int DPC_W      = 33;  // degrees per count, 24 fraction bits
  localparam int ALPHA_W    = 17;  // filter weight, 16 fraction bits
  localparam int DT_W       = 24;  // tick interval in microseconds
  localparam int ANG_W      = 48;  // angle accumulator
  localparam int VEL_W      = 40;  // velocity estimate
  localparam int POS_OUT_W  = 32;  // reported position count
  localparam int US_W       = 20;  // width of the microseconds-per-second constant
  localparam int QUOT_W     = 40;  // quotient bits produced by the divider
  localparam int DIV_W      = DT_W + 8;  // divisor is dt * 256
  localparam int CNT_W      = $clog2(QUOT_W);
  localparam int FUNC_W     = 2;
  localparam int ANG_SHIFT  = 8;   // 24 scale fraction bits down to 16
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DPC_W;

  localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

  localparam logic [FUNC_W-1:0] FUNC_EDGE_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EDGE_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DPC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h10000;

  // operand control of the shared adder
  typedef struct packed {
    logic inv_a;
    logic inv_b;
    logic cin;
  } alu_ctl_t;

endpackage

// ===== src/qdve_if.sv =====
// item and result channels of the quadrature decoder velocity estimator
interface qdve_in_if import qdve_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              level_a;
  logic              level_b;
  logic [DT_W-1:0]   dt_us;

  modport source (output valid, func, level_a, level_b, dt_us, input ready);
  modport sink   (input valid, func, level_a, level_b, dt_us, output ready);
endinterface

interface qdve_out_if import qdve_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [POS_OUT_W-1:0] position_count;
  logic signed [ANG_W-1:0]     angle_out;
  logic signed [VEL_W-1:0]     velocity_out;

  modport source (output valid, position_count, angle_out, velocity_out, input ready);
  modport sink   (input valid, position_count, angle_out, velocity_out, output ready);
endinterface

// ===== src/qdve_alu.sv =====
// shared adder/subtractor with carry out, used for the sequenced multiply, divide and filter arithmetic
module qdve_alu import qdve_pkg::*; #(
  parameter int W = 85
) (
  input  alu_ctl_t     ctl,
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  output logic [W:0]   sum
);

  logic [W-1:0] a_eff;
  logic [W-1:0] b_eff;

  assign a_eff = ctl.inv_a ? ~opa : opa;
  assign b_eff = ctl.inv_b ? ~opb : opb;
  assign sum   = {1'b0, a_eff} + {1'b0, b_eff} + {{W{1'b0}}, ctl.cin};

endmodule

// ===== src/quadrature_decoder_velocity_estimator.sv =====
// top level: quadrature counter with angle accumulation and filtered velocity
//
//   port     dir  contents
//   in_ch    in   func, level_a, level_b, dt_us (valid/ready)
//   out_ch   out  position_count, angle_out, velocity_out (valid/ready)
//   cfg_*    in   cfg_we, cfg_idx, cfg_data (write only)
//
// edges, unused codes and skipped ticks go from accept straight to S_DONE,
// which loads the result register once the output register is free
// an effective tick runs through the steps below before S_DONE,
// all on the one shared adder:
//   delta*scale shift-add (up to 33 steps), times 1e6 (20 steps),
//   restoring divide by dt*256 (40 steps, skipped on overflow), filter (16,
//   skipped for alpha 0 or >= 1.0), each shift-add pass ending once its multiplier runs out
// in_ch.ready is high only while idle; a finished result waits in the
// output register, so the next beat can be taken while out_ch is stalled
// rst_n is synchronous, active low; config registers reset to 0 and 1.0
module quadrature_decoder_velocity_estimator import qdve_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  qdve_in_if.sink              in_ch,
  qdve_out_if.source           out_ch,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_idx,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // datapath width covers |delta| * scale * 1e6 + dt*128
  localparam int W         = COUNT_BITS + DPC_W + US_W;
  localparam int DIV_SHIFT = DIV_W - DT_W;

  localparam logic [W-1:0]      ANG_HALF  = W'(1) << (ANG_SHIFT - 1);
  localparam logic [FRAC_W-1:0] FRAC_HALF = {1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic [VEL_W-1:0]  VEL_MAX   = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0]  VEL_MIN   = {1'b1, {(VEL_W-1){1'b0}}};

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAG  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_ANG  = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_SAT  = 4'd7;
  localparam logic [3:0] S_DIFF = 4'd8;
  localparam logic [3:0] S_FILT = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]             state_r, state_nxt;
  logic [COUNT_BITS-1:0]  pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]  last_r, last_nxt;
  logic [COUNT_BITS-1:0]  delta_r, delta_nxt;
  logic [ANG_W-1:0]       angle_r, angle_nxt;
  logic [ANG_W-1:0]       step_r, step_nxt;
  logic signed [VEL_W-1:0] vel_r, vel_nxt;
  logic signed [VEL_W-1:0] inst_r, inst_nxt;
  logic [W-1:0]           acc_r, acc_nxt;
  logic [W-1:0]           mcand_r, mcand_nxt;
  logic [DPC_W-1:0]       mplr_r, mplr_nxt;
  logic [DIV_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   big_r, big_nxt;
  logic [DT_W-1:0]        dt_r, dt_nxt;
  logic [DPC_W-1:0]       dpc_r, dpc_nxt;
  logic [ALPHA_W-1:0]     alpha_r, alpha_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [POS_OUT_W-1:0]   out_pos_r, out_pos_nxt;
  logic [ANG_W-1:0]       out_ang_r, out_ang_nxt;
  logic [VEL_W-1:0]       out_vel_r, out_vel_nxt;

  logic                   in_acc;
  logic                   same_lvl;
  logic [DIV_W-1:0]       divisor;
  logic [DIV_W:0]         trial;
  logic [QUOT_W-1:0]      quot;
  logic [POS_OUT_W-1:0]   pos_view;

  alu_ctl_t               alu_ctl;
  logic [W-1:0]           alu_a;
  logic [W-1:0]           alu_b;
  logic [W:0]             alu_sum;
  logic                   alu_carry;

  qdve_alu #(.W(W)) u_alu (
    .ctl (alu_ctl),
    .opa (alu_a),
    .opb (alu_b),
    .sum (alu_sum)
  );

  assign alu_carry = alu_sum[W];

  // reported count is the low 32 bits of the sign-extended count
  generate
    if (COUNT_BITS >= POS_OUT_W) begin : g_pos_trunc
      assign pos_view = pos_r[POS_OUT_W-1:0];
    end else begin : g_pos_sext
      assign pos_view = {{(POS_OUT_W-COUNT_BITS){pos_r[COUNT_BITS-1]}}, pos_r};
    end
  endgenerate

  assign in_ch.ready           = (state_r == S_IDLE);
  assign in_acc                = in_ch.valid & in_ch.ready;
  assign same_lvl              = (in_ch.level_a == in_ch.level_b);
  assign divisor               = {dt_r, {DIV_SHIFT{1'b0}}};
  assign trial                 = {rem_r, acc_r[QUOT_W-1]};
  assign quot                  = acc_r[QUOT_W-1:0];

  assign out_ch.valid          = out_valid_r;
  assign out_ch.position_count = $signed(out_pos_r);
  assign out_ch.angle_out      = $signed(out_ang_r);
  assign out_ch.velocity_out   = $signed(out_vel_r);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    delta_nxt     = delta_r;
    angle_nxt     = angle_r;
    step_nxt      = step_r;
    vel_nxt       = vel_r;
    inst_nxt      = inst_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplr_nxt      = mplr_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    big_nxt       = big_r;
    dt_nxt        = dt_r;
    dpc_nxt       = dpc_r;
    alpha_nxt     = alpha_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_ang_nxt   = out_ang_r;
    out_vel_nxt   = out_vel_r;
    alu_ctl       = '0;
    alu_a         = '0;
    alu_b         = '0;

    // config writes are to be issued only while no beat is in flight; the block does not enforce this
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DPC:   dpc_nxt   = cfg_data;
        CFG_ALPHA: alpha_nxt = cfg_data[ALPHA_W-1:0];
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r) inside
      S_IDLE: begin
        if (in_acc) begin
          dt_nxt    = in_ch.dt_us;
          state_nxt = S_DONE;
          unique case (in_ch.func)
            // x4 rule: on A count up when levels agree, on B when they differ
            FUNC_EDGE_A: pos_nxt = same_lvl ? pos_r + COUNT_BITS'(1)
                                            : pos_r - COUNT_BITS'(1);
            FUNC_EDGE_B: pos_nxt = same_lvl ? pos_r - COUNT_BITS'(1)
                                            : pos_r + COUNT_BITS'(1);
            FUNC_TICK: begin
              // zero dt or zero scale leaves everything alone
              if (in_ch.dt_us != '0 && dpc_r != '0) begin
                delta_nxt = pos_r - last_r;
                last_nxt  = pos_r;
                state_nxt = S_MAG;
              end
            end
            default: ;
          endcase
        end
      end

      S_MAG: begin
        // magnitude of the signed delta through the adder
        alu_ctl.inv_a = delta_r[COUNT_BITS-1];
        alu_ctl.cin   = delta_r[COUNT_BITS-1];
        alu_a         = W'(delta_r);
        neg_nxt       = delta_r[COUNT_BITS-1];
        mcand_nxt     = W'(alu_sum[COUNT_BITS-1:0]);
        acc_nxt       = '0;
        mplr_nxt      = dpc_r;
        state_nxt     = S_MUL1;
      end

      S_MUL1, S_MUL2, S_FILT: begin
        // shift-add, stops once the remaining multiplier bits are zero
        if (mplr_r == '0) begin
          unique case (state_r)
            S_MUL1:  state_nxt = S_ANG;
            S_MUL2:  state_nxt = S_CHK;
            default: state_nxt = S_FIN;
          endcase
        end else begin
          alu_a     = acc_r;
          alu_b     = mplr_r[0] ? mcand_r : '0;
          acc_nxt   = alu_sum[W-1:0];
          mcand_nxt = mcand_r << 1;
          mplr_nxt  = mplr_r >> 1;
        end
      end

      S_ANG: begin
        // signed angle step with rounding, then set up the times-1e6 pass
        alu_ctl.inv_a = neg_r;
        alu_ctl.cin   = neg_r;
        alu_a         = acc_r;
        alu_b         = ANG_HALF;
        step_nxt      = alu_sum[ANG_SHIFT +: ANG_W];
        mcand_nxt     = acc_r;
        acc_nxt       = W'({dt_r, {(DIV_SHIFT-1){1'b0}}});
        mplr_nxt      = DPC_W'(US_PER_S);
        state_nxt     = S_MUL2;
      end

      S_CHK: begin
        // quotient fits the divider only if the high part is below the divisor
        angle_nxt     = angle_r + step_r;
        alu_ctl.inv_b = 1'b1;
        alu_ctl.cin   = 1'b1;
        alu_a         = acc_r >> QUOT_W;
        alu_b         = W'(divisor);
        big_nxt       = alu_carry;
        rem_nxt       = DIV_W'(acc_r >> QUOT_W);
        cnt_nxt       = '0;
        state_nxt     = alu_carry ? S_SAT : S_DIV;
      end

      S_DIV: begin
        // one restoring step, quotient bits shift in behind the dividend
        alu_ctl.inv_b = 1'b1;
        alu_ctl.cin   = 1'b1;
        alu_a         = W'(trial);
        alu_b         = W'(divisor);
        rem_nxt       = alu_carry ? alu_sum[DIV_W-1:0] : trial[DIV_W-1:0];
        acc_nxt[QUOT_W-1:0] = {acc_r[QUOT_W-2:0], alu_carry};
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          state_nxt = S_SAT;
        end
      end

      S_SAT: begin
        // sign and saturate the instantaneous velocity
        alu_ctl.inv_a = 1'b1;
        alu_ctl.cin   = 1'b1;
        alu_a         = W'(quot);
        if (neg_r) begin
          if (big_r || (quot[QUOT_W-1] && quot[QUOT_W-2:0] != '0)) begin
            inst_nxt = $signed(VEL_MIN);
          end else begin
            inst_nxt = $signed(alu_sum[VEL_W-1:0]);
          end
        end else begin
          if (big_r || quot[QUOT_W-1]) begin
            inst_nxt = $signed(VEL_MAX);
          end else begin
            inst_nxt = $signed(quot[VEL_W-1:0]);
          end
        end
        if (alpha_r[ALPHA_W-1]) begin
          vel_nxt   = inst_nxt;
          state_nxt = S_DONE;
        end else if (alpha_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIFF;
        end
      end

      S_DIFF: begin
        // v + (inst - v) * alpha, with v pre-scaled and the rounding half added
        alu_ctl.inv_b = 1'b1;
        alu_ctl.cin   = 1'b1;
        alu_a         = W'(inst_r);
        alu_b         = W'(vel_r);
        mcand_nxt     = alu_sum[W-1:0];
        acc_nxt       = W'($signed({vel_r, FRAC_HALF}));
        mplr_nxt      = DPC_W'(alpha_r[FRAC_W-1:0]);
        state_nxt     = S_FILT;
      end

      S_FIN: begin
        // arithmetic shift gives the floor
        vel_nxt   = $signed(acc_r[FRAC_W +: VEL_W]);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_view;
          out_ang_nxt   = angle_r;
          out_vel_nxt   = vel_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      last_r      <= '0;
      angle_r     <= '0;
      vel_r       <= '0;
      dpc_r       <= '0;
      alpha_r     <= ALPHA_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      last_r      <= last_nxt;
      angle_r     <= angle_nxt;
      vel_r       <= vel_nxt;
      dpc_r       <= dpc_nxt;
      alpha_r     <= alpha_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r   <= delta_nxt;
    step_r    <= step_nxt;
    inst_r    <= inst_nxt;
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    mplr_r    <= mplr_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    big_r     <= big_nxt;
    dt_r      <= dt_nxt;
    out_pos_r <= out_pos_nxt;
    out_ang_r <= out_ang_nxt;
    out_vel_r <= out_vel_nxt;
  end

  // an edge always moves the count by one
  a_edge_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.func == FUNC_EDGE_A || in_ch.func == FUNC_EDGE_B)
      |=> pos_r != $past(pos_r))
    else $error("edge beat did not step the count");

  // an unused code leaves the count, angle and velocity alone
  a_none_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.func == FUNC_NONE
      |=> $stable(pos_r) && $stable(angle_r) && $stable(vel_r))
    else $error("unused code changed state");

  // the tick reference only moves when a tick is taken
  a_last_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_ch.func == FUNC_TICK) |=> $stable(last_r))
    else $error("tick reference moved without a tick");

  // restoring divide keeps the partial remainder below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < divisor)
    else $error("divider remainder out of range");

  // a finished item lands in the output register with the current count
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || out_ch.ready)
      |=> out_valid_r && out_pos_r == $past(pos_view))
    else $error("result not loaded from finished item");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the quadrature decoder velocity estimator
module tb;
  import qdve_pkg::*;

  localparam int CNT_BITS    = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 165;
  localparam int TAIL_CYCLES = 130;   // longest tick plus margin

  localparam logic [DPC_W-1:0]   DPC_MAX   = '1;
  localparam logic [DPC_W-1:0]   DPC_ONE   = 33'd16777216;  // 1.0 degree per count
  localparam logic [ALPHA_W-1:0] ALPHA_TOP = '1;            // above 1.0, acts as a load
  localparam logic [DT_W-1:0]    DT_MAX    = '1;

  // {a,b} levels of the four quadrature phases, phase 0 in the low bits
  localparam logic [7:0] GRAY_AB = 8'b01_11_10_00;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              level_a;
    logic              level_b;
    logic [DT_W-1:0]   dt_us;
  } move_t;

  typedef struct packed {
    logic signed [POS_OUT_W-1:0] pos;
    logic signed [ANG_W-1:0]     ang;
    logic signed [VEL_W-1:0]     vel;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  qdve_in_if  in_ch ();
  qdve_out_if out_ch ();

  quadrature_decoder_velocity_estimator #(
    .COUNT_BITS(CNT_BITS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted block state and register copies
  logic [31:0]             cnt_now = '0;
  logic [31:0]             cnt_at_tick = '0;
  logic [ANG_W-1:0]        angle_m = '0;
  logic signed [VEL_W-1:0] vel_m = '0;
  logic [DPC_W-1:0]        scale_m = '0;
  logic [ALPHA_W-1:0]      alpha_m = ALPHA_RESET;

  move_t    pending_moves[$];       // items waiting for the driver
  reading_t expected_readings[$];   // predicted results, oldest first

  int in_flight = 0;      // queued or on the bus, not yet accepted
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int ticks_applied = 0;
  int rates_clipped = 0;
  int settings_used = 0;
  int cycle_cnt = 0;
  int gap_pct = 0;        // chance per cycle to start an idle burst, both sides
  int in_gap = 0;
  int out_gap = 0;
  bit in_taken = 1'b0;
  int enc_phase = 0;
  int enc_dir = 1;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // instantaneous rate: |delta| * scale * 1e6 / (dt * 256), rounded half away
  // from zero, signed by delta and clipped to the 40-bit range
  function automatic logic signed [VEL_W-1:0] tick_rate(logic [31:0] delta,
                                                        logic [DPC_W-1:0] scale,
                                                        logic [DT_W-1:0] dt);
    logic [127:0] mag, den, num, quo;
    logic         neg;
    neg = delta[31];
    mag = {96'd0, neg ? (~delta + 32'd1) : delta};
    den = {96'd0, dt, 8'd0};
    num = mag * {108'd0, US_PER_S} * {95'd0, scale} + (den >> 1);
    quo = num / den;
    if (neg) begin
      if (quo > (128'd1 << 39)) begin
        quo = 128'd1 << 39;
        rates_clipped++;
      end
      return ~quo[VEL_W-1:0] + 40'd1;
    end
    if (quo > {89'd0, {39{1'b1}}}) begin
      quo = {89'd0, {39{1'b1}}};
      rates_clipped++;
    end
    return quo[VEL_W-1:0];
  endfunction

  // apply one accepted item to the predicted state, return what should come out
  function automatic reading_t step_encoder(move_t m);
    logic                    same, up;
    logic [31:0]             delta;
    logic [63:0]             prod;
    logic signed [VEL_W-1:0] rate;
    longint                  mix;
    reading_t                r;
    same = (m.level_a == m.level_b);
    if (m.func == FUNC_EDGE_A || m.func == FUNC_EDGE_B) begin
      // x4 rule: the direction follows from which line moved and the levels
      up = (m.func == FUNC_EDGE_A) ? same : !same;
      cnt_now = up ? cnt_now + 32'd1 : cnt_now - 32'd1;
    end else if (m.func == FUNC_TICK && m.dt_us != 0 && scale_m != 0) begin
      delta = cnt_now - cnt_at_tick;
      cnt_at_tick = cnt_now;
      // angle step is (delta*scale + 128) >> 8; only bits 8..55 survive the wrap
      prod = {{32{delta[31]}}, delta} * {31'd0, scale_m} + 64'd128;
      angle_m = angle_m + prod[55:8];
      rate = tick_rate(delta, scale_m, m.dt_us);
      ticks_applied++;
      if (alpha_m >= ALPHA_RESET) begin
        vel_m = rate;
      end else if (alpha_m != 0) begin
        // weighted sum, then floor division by 65536 via arithmetic shift
        mix = longint'(vel_m) * (65536 - longint'(alpha_m))
            + longint'(rate) * longint'(alpha_m) + 32768;
        vel_m = VEL_W'(mix >>> FRAC_W);
      end
      // alpha of zero holds the estimate
    end
    // skipped ticks and the unused code leave the state alone
    r.pos = cnt_now;
    r.ang = angle_m;
    r.vel = vel_m;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // input driver: changes at the falling edge, holds a beat until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    move_t cur;
    if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_moves.size() != 0 && gap_pct != 0 &&
                   $urandom_range(0, 99) < gap_pct) begin
        // start an idle burst with valid held low
        in_gap = $urandom_range(1, 17) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_moves.size() != 0) begin
        // valid stays high across back-to-back beats
        cur = pending_moves.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.func    <= cur.func;
        in_ch.level_a <= cur.level_a;
        in_ch.level_b <= cur.level_b;
        in_ch.dt_us   <= cur.dt_us;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, same burst scheme
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitors: sample at the rising edge
  // ---------------------------------------------------------------------------

  // accepted input beat: predict right away, the registers are stable here
  always @(posedge clk) begin : watch_in
    move_t m;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      m.func    = in_ch.func;
      m.level_a = in_ch.level_a;
      m.level_b = in_ch.level_b;
      m.dt_us   = in_ch.dt_us;
      expected_readings.push_back(step_encoder(m));
      in_taken = 1'b1;
      in_flight--;
      beats_in++;
    end
  end

  // accepted result beat: compare field by field with the oldest prediction
  always @(posedge clk) begin : watch_out
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_out++;
      if (expected_readings.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d with nothing expected", beats_out));
      end else begin
        want = expected_readings.pop_front();
        if (out_ch.position_count !== want.pos)
          flag_mismatch($sformatf("beat %0d position_count got %0d expected %0d",
                                  beats_out, out_ch.position_count, want.pos));
        if (out_ch.angle_out !== want.ang)
          flag_mismatch($sformatf("beat %0d angle_out got %0d expected %0d",
                                  beats_out, out_ch.angle_out, want.ang));
        if (out_ch.velocity_out !== want.vel)
          flag_mismatch($sformatf("beat %0d velocity_out got %0d expected %0d",
                                  beats_out, out_ch.velocity_out, want.vel));
      end
    end
  end

  always @(posedge clk) cycle_cnt++;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_cnt, expected_readings.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_move(logic [FUNC_W-1:0] f, logic a, logic b, logic [DT_W-1:0] dt);
    move_t m;
    m.func    = f;
    m.level_a = a;
    m.level_b = b;
    m.dt_us   = dt;
    pending_moves.push_back(m);
    in_flight++;
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == CFG_DPC)
      scale_m = data[DPC_W-1:0];
    else
      alpha_m = data[ALPHA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [DPC_W-1:0] dpc, logic [ALPHA_W-1:0] alpha);
    write_reg(CFG_DPC, dpc);
    write_reg(CFG_ALPHA, {{(CFG_DATA_W-ALPHA_W){1'b0}}, alpha});
    settings_used++;
  endtask

  // wait until every queued item is taken and every result has come out
  task automatic drain();
    while (in_flight != 0 || expected_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one well-formed quadrature edge in the given direction
  task automatic turn(int dir);
    logic [1:0] prev_ab, next_ab;
    prev_ab = GRAY_AB[2*enc_phase +: 2];
    enc_phase = (enc_phase + dir + 4) % 4;
    next_ab = GRAY_AB[2*enc_phase +: 2];
    queue_move((prev_ab[1] != next_ab[1]) ? FUNC_EDGE_A : FUNC_EDGE_B,
               next_ab[1], next_ab[0], DT_W'($urandom_range(0, DT_MAX)));
  endtask

  function automatic logic [DT_W-1:0] pick_dt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'd1;
      2:       return DT_W'($urandom_range(0, DT_MAX));
      3:       return DT_MAX;
      default: return DT_W'($urandom_range(1, 5000));
    endcase
  endfunction

  // mostly a shaft turning back and forth with ticks mixed in, plus noise
  task automatic random_run(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        if ($urandom_range(0, 15) == 0)
          enc_dir = -enc_dir;
        turn(enc_dir);
      end else if (pick < 74) begin
        // edge with arbitrary levels, not following the gray sequence
        queue_move($urandom_range(0, 1) ? FUNC_EDGE_B : FUNC_EDGE_A,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   DT_W'($urandom_range(0, DT_MAX)));
      end else if (pick < 96) begin
        queue_move(FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   pick_dt());
      end else begin
        queue_move(FUNC_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   DT_W'($urandom_range(0, DT_MAX)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [DPC_W-1:0]   dpc;
    logic [ALPHA_W-1:0] alpha;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_EDGE_A;
    in_ch.level_a = 1'b0;
    in_ch.level_b = 1'b0;
    in_ch.dt_us   = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_DPC;
    cfg_data      = '0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    settings_used = 1;
    gap_pct = 20;

    // reset settings: scale is zero so every tick is skipped
    // all level combinations on both lines, net count back to zero
    queue_move(FUNC_EDGE_A, 1'b1, 1'b1, '0);
    queue_move(FUNC_EDGE_A, 1'b0, 1'b0, DT_MAX);
    queue_move(FUNC_EDGE_A, 1'b1, 1'b0, '0);
    queue_move(FUNC_EDGE_A, 1'b0, 1'b1, DT_MAX);
    queue_move(FUNC_EDGE_B, 1'b1, 1'b1, '0);
    queue_move(FUNC_EDGE_B, 1'b0, 1'b0, DT_MAX);
    queue_move(FUNC_EDGE_B, 1'b1, 1'b0, '0);
    queue_move(FUNC_EDGE_B, 1'b0, 1'b1, DT_MAX);
    queue_move(FUNC_NONE, 1'b1, 1'b1, DT_MAX);
    queue_move(FUNC_TICK, 1'b0, 1'b0, 24'd100);
    drain();

    // one degree per count, direct load: zero delta, zero dt, small motion
    set_regs(DPC_ONE, ALPHA_RESET);
    queue_move(FUNC_TICK, 1'b1, 1'b0, 24'd1000);
    queue_move(FUNC_TICK, 1'b0, 1'b1, '0);
    repeat (3) queue_move(FUNC_EDGE_A, 1'b1, 1'b1, '0);
    queue_move(FUNC_TICK, 1'b0, 1'b0, 24'd1);
    drain();

    // largest scale with the filter holding its value
    set_regs(DPC_MAX, '0);
    repeat (2) queue_move(FUNC_EDGE_B, 1'b1, 1'b1, '0);
    queue_move(FUNC_TICK, 1'b1, 1'b1, 24'd1);
    drain();

    // weight above 1.0 loads: negative clip, then a zero delta over the longest dt
    write_reg(CFG_ALPHA, {{(CFG_DATA_W-ALPHA_W){1'b0}}, ALPHA_TOP});
    settings_used++;
    repeat (3) queue_move(FUNC_EDGE_A, 1'b0, 1'b1, '0);
    queue_move(FUNC_TICK, 1'b0, 1'b1, 24'd1);
    queue_move(FUNC_TICK, 1'b1, 1'b0, DT_MAX);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          dpc   = DPC_W'($urandom_range(1, 1 << 24));
          alpha = ALPHA_W'($urandom_range(1, 65535));
        end
        1: begin
          dpc   = 33'd1;
          alpha = 17'd65535;
        end
        2: begin
          dpc   = DPC_MAX;
          alpha = 17'd1;
        end
        3: begin
          dpc   = {1'($urandom_range(0, 1)), 32'($urandom)};
          alpha = '0;
        end
        4: begin
          dpc   = {1'b0, 32'($urandom)};
          alpha = ALPHA_RESET;
        end
        default: begin
          dpc   = DPC_W'($urandom_range(1, 1 << 22));
          alpha = ALPHA_W'($urandom_range(0, ALPHA_TOP));
        end
      endcase
      set_regs(dpc, alpha);
      // no idling at all in the closing phase
      gap_pct = (ph == RAND_PHASES - 1) ? 0 : $urandom_range(0, 40);
      random_run(PHASE_ITEMS);
      drain();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived",
                              expected_readings.size()));

    $display("covered %0d items and %0d results over %0d register settings",
             beats_in, beats_out, settings_used);
    $display("%0d ticks updated angle and velocity, %0d rates clipped at the range",
             ticks_applied, rates_clipped);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/qdve_pkg.sv
src/qdve_if.sv
src/qdve_alu.sv
src/quadrature_decoder_velocity_estimator.sv
verif/tb.sv
